// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ahl_pkg.sv
// Types, constants and defaults of the asymmetric half-wave lowpass unit.
package ahl_pkg;

  localparam int CHANNEL_COUNT_DEF   = 2;
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int STATE_FRAC_BITS_DEF = 16;

  localparam int COEF_W    = 16;
  localparam int Q15_SHIFT = 15;
  localparam int Q15_HALF  = 16384;
  localparam logic [COEF_W-1:0] Q15_ONE = 16'd32768;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;

  localparam logic [COEF_W-1:0] POS_COEF_RST   = 16'd4021;
  localparam logic [COEF_W-1:0] NEG_COEF_RST   = 16'd847;
  localparam logic [COEF_W-1:0] WET_AMOUNT_RST = 16'd16384;

  typedef enum logic [1:0] {
    REG_POS_COEF   = 2'd0,
    REG_NEG_COEF   = 2'd1,
    REG_WET_AMOUNT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_POS = 2'd0,
    MUL_NEG = 2'd1,
    MUL_WET = 2'd2
  } mul_sel_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIFF = 8'b0000_0010,
    ST_MPOS = 8'b0000_0100,
    ST_MNEG = 8'b0000_1000,
    ST_UNEG = 8'b0001_0000,
    ST_DWET = 8'b0010_0000,
    ST_MWET = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     load_diff;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_pos;
    logic     upd_neg;
    logic     load_wet;
    logic     load_out;
  } cmd_t;

endpackage

// File: rtl/asymmetric_halfwave_lowpass_unit.sv
// Top level of the asymmetric half-wave lowpass unit: APB registers and core.
// Each sample is split into its positive and negative half; each half runs
// through its own one-pole lowpass (Q1.15 coefficients, values above 1.0 act
// as 1.0) whose state is kept per channel and cleared by reset, and the
// summed states are blended with the dry sample by wet_amount, rounded half
// up and saturated. An accepted sample steps through the states DIFF, MPOS,
// MNEG, UNEG, DWET, MWET and EMIT, where its result is loaded into the output
// register once the output side is free; a new sample is taken in the cycle
// that result is loaded, so no sample is taken while one is in work. The
// steps come from the single 17 x (SAMPLE_BITS+STATE_FRAC_BITS+1) bit
// multiplier, used in turn for the positive filter, the negative filter and
// the blend, each product registered before use. Channels of CHANNEL_COUNT
// or more share the last channel's state; channel_out_o echoes channel_in_i.
// Registers: 0x0 positive coefficient, 0x4 negative coefficient,
// 0x8 wet amount (16 bits each); write only while the unit is idle.
`include "assert_macros.svh"

module asymmetric_halfwave_lowpass_unit #(
  parameter int CHANNEL_COUNT   = ahl_pkg::CHANNEL_COUNT_DEF,
  parameter int SAMPLE_BITS     = ahl_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_FRAC_BITS = ahl_pkg::STATE_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ahl_pkg::PADDR_W-1:0]      paddr,
  input  logic [ahl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ahl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in_i,
  input  logic                             channel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    sample_out_o,
  output logic                             channel_out_o
);
  import ahl_pkg::*;

  logic [COEF_W-1:0] pos_coef_q, neg_coef_q, wet_amount_q;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  cmd_t              cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_coef_q   <= POS_COEF_RST;
      neg_coef_q   <= NEG_COEF_RST;
      wet_amount_q <= WET_AMOUNT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_POS_COEF:   pos_coef_q   <= pwdata[COEF_W-1:0];
        REG_NEG_COEF:   neg_coef_q   <= pwdata[COEF_W-1:0];
        REG_WET_AMOUNT: wet_amount_q <= pwdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POS_COEF:   prdata = APB_DATA_W'(pos_coef_q);
      REG_NEG_COEF:   prdata = APB_DATA_W'(neg_coef_q);
      REG_WET_AMOUNT: prdata = APB_DATA_W'(wet_amount_q);
      default:        prdata = '0;
    endcase
  end

  ahl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ahl_datapath #(
    .CHANNEL_COUNT   (CHANNEL_COUNT),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .pos_coef_i   (pos_coef_q),
    .neg_coef_i   (neg_coef_q),
    .wet_amount_i (wet_amount_q),
    .sample_i     (sample_in_i),
    .channel_i    (channel_in_i),
    .sample_o     (sample_out_o),
    .channel_o    (channel_out_o)
  );

  `ASSERT_NEXT(a_cfg_pos_write, clk_i, rst_ni, cfg_wr && (reg_idx == REG_POS_COEF), pos_coef_q == $past(pwdata[COEF_W-1:0]), "positive coefficient write lost")
  `ASSERT_IMPLIES(a_out_no_overwrite, clk_i, rst_ni, cmd.load_out, !out_valid_o || !out_stall_i, "output beat overwritten while stalled")
  `ASSERT_NEXT(a_accept_starts_work, clk_i, rst_ni, in_valid_i && !in_stall_o, cmd.load_diff, "accepted beat not processed")
  `ASSERT_IMPLIES(a_single_step, clk_i, rst_ni, 1'b1, $onehot0({cmd.load_diff, cmd.mul_en, cmd.upd_neg, cmd.load_wet, cmd.load_out}), "datapath steps overlap")

endmodule

// File: rtl/ahl_ctrl.sv
// Sequencing state machine and handshake control of the lowpass unit.
module ahl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ahl_pkg::cmd_t cmd_o
);
  import ahl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_ready;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    in_ready = 1'b0;
    out_free = !out_valid_q || !out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.load_diff = 1'b1;
        state_d = ST_MPOS;
      end
      ST_MPOS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_POS;
        state_d = ST_MNEG;
      end
      ST_MNEG: begin
        cmd_o.upd_pos = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_NEG;
        state_d = ST_UNEG;
      end
      ST_UNEG: begin
        cmd_o.upd_neg = 1'b1;
        state_d = ST_DWET;
      end
      ST_DWET: begin
        cmd_o.load_wet = 1'b1;
        state_d = ST_MWET;
      end
      ST_MWET: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_WET;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          in_ready = 1'b1;
          state_d = in_valid_i ? ST_DIFF : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.load_in = in_ready && in_valid_i;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ahl_datapath.sv
// Filter states, shared Q1.15 multiplier, blend, rounding and output register.
module ahl_datapath #(
  parameter int CHANNEL_COUNT   = ahl_pkg::CHANNEL_COUNT_DEF,
  parameter int SAMPLE_BITS     = ahl_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_FRAC_BITS = ahl_pkg::STATE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ahl_pkg::cmd_t                 cmd_i,
  input  logic [ahl_pkg::COEF_W-1:0]    pos_coef_i,
  input  logic [ahl_pkg::COEF_W-1:0]    neg_coef_i,
  input  logic [ahl_pkg::COEF_W-1:0]    wet_amount_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          channel_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          channel_o
);
  import ahl_pkg::*;

  localparam int StateW = SAMPLE_BITS + STATE_FRAC_BITS;
  localparam int DiffW  = StateW + 1;
  localparam int ProdW  = DiffW + COEF_W + 1;
  localparam int IdxW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic signed [ProdW-1:0] ProdHalf = ProdW'(Q15_HALF);
  localparam logic signed [DiffW-1:0] OutHalf =
    {{(DiffW-1){1'b0}}, 1'b1} << (STATE_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          ch_q;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic signed [StateW-1:0]      spos_q [CHANNEL_COUNT];
  logic signed [StateW-1:0]      sneg_q [CHANNEL_COUNT];
  logic signed [DiffW-1:0]       diff_a_q, diff_b_q;
  logic signed [ProdW-1:0]       prod_q, prod_d;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          channel_out_q;

  logic signed [StateW-1:0]      xs, pp, np, spos_cur, sneg_cur;
  logic signed [DiffW-1:0]       diff_pos, diff_neg, diff_wet;
  logic [COEF_W-1:0]             k_raw, k_clamped;
  logic signed [COEF_W:0]        mul_k;
  logic signed [DiffW-1:0]       mul_d;
  logic signed [ProdW-1:0]       prod_rnd, prod_shr;
  logic signed [DiffW-1:0]       scaled;
  logic signed [DiffW-1:0]       sum_pos, sum_neg, blend, blend_rnd, blend_shr;
  logic signed [SAMPLE_BITS:0]   y_wide;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  assign idx_d = (int'(channel_i) >= CHANNEL_COUNT) ? IdxW'(CHANNEL_COUNT - 1)
                                                    : IdxW'(channel_i);

  assign xs       = {x_q, {STATE_FRAC_BITS{1'b0}}};
  assign pp       = (!x_q[SAMPLE_BITS-1] && (x_q != '0)) ? xs : '0;
  assign np       = x_q[SAMPLE_BITS-1] ? xs : '0;
  assign spos_cur = spos_q[idx_q];
  assign sneg_cur = sneg_q[idx_q];

  assign diff_pos = DiffW'(pp) - DiffW'(spos_cur);
  assign diff_neg = DiffW'(np) - DiffW'(sneg_cur);
  assign diff_wet = DiffW'(spos_cur) + DiffW'(sneg_cur) - DiffW'(xs);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_POS: begin
        k_raw = pos_coef_i;
        mul_d = diff_a_q;
      end
      MUL_NEG: begin
        k_raw = neg_coef_i;
        mul_d = diff_b_q;
      end
      MUL_WET: begin
        k_raw = wet_amount_i;
        mul_d = diff_a_q;
      end
      default: begin
        k_raw = '0;
        mul_d = '0;
      end
    endcase
  end

  assign k_clamped = (k_raw > Q15_ONE) ? Q15_ONE : k_raw;
  assign mul_k     = $signed({1'b0, k_clamped});
  assign prod_d    = ProdW'(mul_k) * ProdW'(mul_d);

  assign prod_rnd = prod_q + ProdHalf;
  assign prod_shr = prod_rnd >>> Q15_SHIFT;
  assign scaled   = prod_shr[DiffW-1:0];

  assign sum_pos = DiffW'(spos_cur) + scaled;
  assign sum_neg = DiffW'(sneg_cur) + scaled;

  assign blend     = DiffW'(xs) + scaled;
  assign blend_rnd = blend + OutHalf;
  assign blend_shr = blend_rnd >>> STATE_FRAC_BITS;
  assign y_wide    = blend_shr[SAMPLE_BITS:0];

  always_comb begin
    if (y_wide[SAMPLE_BITS] != y_wide[SAMPLE_BITS-1]) begin
      y_sat = y_wide[SAMPLE_BITS] ? SampleMin : SampleMax;
    end else begin
      y_sat = y_wide[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        spos_q[c] <= '0;
        sneg_q[c] <= '0;
      end
    end else begin
      if (cmd_i.upd_pos) spos_q[idx_q] <= sum_pos[StateW-1:0];
      if (cmd_i.upd_neg) sneg_q[idx_q] <= sum_neg[StateW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q   <= sample_i;
      ch_q  <= channel_i;
      idx_q <= idx_d;
    end
    if (cmd_i.load_diff) begin
      diff_a_q <= diff_pos;
      diff_b_q <= diff_neg;
    end else if (cmd_i.load_wet) begin
      diff_a_q <= diff_wet;
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.load_out) begin
      sample_out_q  <= y_sat;
      channel_out_q <= ch_q;
    end
  end

  assign sample_o  = sample_out_q;
  assign channel_o = channel_out_q;

endmodule
